// File: src/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants for the current change reporter: command codes,
// input and result transaction layouts, configuration register map.
// ----------------------------------------------------------------------------
package ccr_pkg;

    // Table size default
    localparam int CCR_NUM_SLOTS = 8;

    // Field widths
    localparam int CHAN_W = 3;
    localparam int MA_W   = 16;
    localparam int PCT_W  = 8;

    // Relative change is compared in percent
    localparam int PCT_SCALE = 100;

    // Configuration register map (APB byte address = 4 * index)
    localparam int CCR_ADDR_W   = 3;
    localparam int CCR_DATA_W   = 32;
    localparam int CCR_REG_IDX_W = 1;
    localparam logic [CCR_REG_IDX_W-1:0] REG_ZERO_LEVEL = 1'b0;
    localparam logic [CCR_REG_IDX_W-1:0] REG_MIN_CHANGE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [MA_W-1:0]  ZERO_LEVEL_RST = 16'd100;
    localparam logic [PCT_W-1:0] MIN_CHANGE_RST = 8'd10;

    // Input commands
    typedef enum logic {
        CMD_REGISTER = 1'b0,
        CMD_SAMPLE   = 1'b1
    } t_cmd;

    // Input transaction
    typedef struct packed {
        t_cmd              command;
        logic [CHAN_W-1:0] channel;
        logic [MA_W-1:0]   current_ma;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [CHAN_W-1:0] channel_res;
        logic [MA_W-1:0]   current_ma_res;
    } t_out_item;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [MA_W-1:0]  zero_level_ma;
        logic [PCT_W-1:0] min_change_pct;
    } t_cfg;

endpackage

// File: src/ccr_apb_regs.sv
// ----------------------------------------------------------------------------
// ccr_apb_regs
// APB register file holding the zero level and the minimum change percent.
// Writes complete in the access phase; reads return the register value.
// ----------------------------------------------------------------------------
module ccr_apb_regs import ccr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CCR_ADDR_W-1:0] paddr,
    input  logic [CCR_DATA_W-1:0] pwdata,
    output logic [CCR_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [CCR_REG_IDX_W-1:0] w_idx;
    logic                     w_wr;
    t_cfg                     r_cfg;

    // Word index; byte offset bits are don't-care
    assign w_idx  = paddr[2 +: CCR_REG_IDX_W];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_level_ma  <= ZERO_LEVEL_RST;
            r_cfg.min_change_pct <= MIN_CHANGE_RST;
        end else if (w_wr && pready) begin
            unique case (w_idx)
                REG_ZERO_LEVEL: r_cfg.zero_level_ma  <= pwdata[MA_W-1:0];
                REG_MIN_CHANGE: r_cfg.min_change_pct <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_ZERO_LEVEL: prdata = CCR_DATA_W'(r_cfg.zero_level_ma);
            REG_MIN_CHANGE: prdata = CCR_DATA_W'(r_cfg.min_change_pct);
            default:        prdata = '0;
        endcase
    end

endmodule

// File: src/current_change_reporter.sv
// ----------------------------------------------------------------------------
// current_change_reporter
// Send-on-delta reporting of AC current over a small table of channels.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the result channel
// is not stalled. A report is valid in the result register once its input,
// held in the input register, has been processed into it. The whole channel
// lookup across the table, the zero clamp, the percent-change compare and
// the table update are done combinationally between those two registers, so
// back-to-back transactions see each other's table updates with no gap. A
// stalled result holds the result and input registers; the input stalls once
// both registers are full. Register commands never give a result; samples for
// unknown channels are dropped.
// ----------------------------------------------------------------------------
module current_change_reporter import ccr_pkg::*; #(
    parameter int NUM_SLOTS = CCR_NUM_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CCR_ADDR_W-1:0] paddr,
    input  logic [CCR_DATA_W-1:0] pwdata,
    output logic [CCR_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LHS_W = MA_W + 7;
    localparam int RHS_W = MA_W + PCT_W;

    t_cfg w_cfg;

    // Input and result registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // Slot table
    logic [CHAN_W-1:0] r_chan [NUM_SLOTS];
    logic [MA_W-1:0]   r_last [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_force;
    logic [CNT_W-1:0]  r_count;

    logic                 w_adv;
    logic                 w_fire;
    logic                 w_hit;
    logic [IDX_W-1:0]     w_hit_idx;
    logic [IDX_W-1:0]     w_new_idx;
    logic [NUM_SLOTS-1:0] w_used;
    logic                 w_full;
    logic [MA_W-1:0]      w_last;
    logic                 w_forced;
    logic [MA_W-1:0]      w_reading;
    logic [MA_W-1:0]      w_diff;
    logic [LHS_W-1:0]     w_lhs;
    logic [RHS_W-1:0]     w_rhs;
    logic                 w_report;
    logic                 w_is_sample;
    logic                 w_n_out_valid;

    ccr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake: process stage advances when the result register is empty or not stalled
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_fire      = r_in_valid && w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Parallel channel lookup over the occupied slots
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            w_used[i] = CNT_W'(i) < r_count;
            if (w_used[i] && r_chan[i] == r_in.channel) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
        end
    end

    assign w_full    = r_count == CNT_W'(NUM_SLOTS);
    assign w_new_idx = r_count[IDX_W-1:0];
    assign w_last    = r_last[w_hit_idx];
    assign w_forced  = r_force[w_hit_idx];

    // Zero clamp and relative change test
    assign w_reading = (r_in.current_ma < w_cfg.zero_level_ma) ? '0 : r_in.current_ma;
    assign w_diff    = (w_reading >= w_last) ? (w_reading - w_last) : (w_last - w_reading);
    assign w_lhs     = LHS_W'(w_diff) * LHS_W'(PCT_SCALE);
    assign w_rhs     = RHS_W'(w_cfg.min_change_pct) * RHS_W'(w_last);
    assign w_report  = w_forced
                    || (w_last == '0 && w_reading != '0)
                    || (RHS_W'(w_lhs) > w_rhs);

    assign w_is_sample   = r_in.command == CMD_SAMPLE;
    assign w_n_out_valid = w_fire && w_is_sample && w_hit && w_report;

    // Control state: valids, fill count, force flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_force     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= w_n_out_valid;
            end
            if (w_fire) begin
                case (r_in.command)
                    CMD_REGISTER: begin
                        if (w_hit) begin
                            r_force[w_hit_idx] <= 1'b1;
                        end else if (!w_full) begin
                            r_force[w_new_idx] <= 1'b0;
                            r_count            <= r_count + 1'b1;
                        end
                    end
                    CMD_SAMPLE: begin
                        if (w_hit) begin
                            r_force[w_hit_idx] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload: input capture, slot contents, result
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            case (r_in.command)
                CMD_REGISTER: begin
                    if (!w_hit && !w_full) begin
                        r_chan[w_new_idx] <= r_in.channel;
                        r_last[w_new_idx] <= '0;
                    end
                end
                CMD_SAMPLE: begin
                    if (w_hit && w_report) begin
                        r_last[w_hit_idx] <= w_reading;
                    end
                end
                default: ;
            endcase
        end
        if (w_adv && w_n_out_valid) begin
            r_out.channel_res    <= r_in.channel;
            r_out.current_ma_res <= w_reading;
        end
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_SLOTS))
        else $error("slot count above table size");

    a_force_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_force & ~w_used) == '0)
        else $error("force flag set on an unused slot");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a transaction in process");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with a free pipeline");

endmodule
